[hw/rtl/tdf_pkg.sv]
// Package of shared types and constants for the threshold and duplicate filter.
package tdf_pkg;

  // Key length in bits and the number of keys that the table holds.
  localparam int GeneBits   = 64;
  localparam int TableDepth = 1024;

  // Fixed field widths of the item channels.
  localparam int KeyW     = 64;
  localparam int ScoreW   = 32;
  localparam int StatusW  = 3;
  localparam int KeyNumW  = 11;

  // Table address and fill count widths.
  localparam int AddrW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CountW = $clog2(TableDepth + 1);

  // Only the low GeneBits bits of a key take part in anything.
  localparam logic [KeyW-1:0] KeyMask = {KeyW{1'b1}} >> (KeyW - GeneBits);

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StAccepted  = 3'd0,
    StBelow     = 3'd1,
    StDuplicate = 3'd2,
    StFull      = 3'd3,
    StPreloaded = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    CtrlIdle,
    CtrlSearch,
    CtrlFinish
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    search;
    logic    load;
    logic    store;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic preload;
    logic below;
    logic hit;
    logic full;
    logic issue_done;
    logic rd_pending;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/tdf_if.sv]
// Item channel interfaces: the input item channel and the result item channel.
interface tdf_in_if
  import tdf_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [KeyW-1:0]          key_bits;
  logic signed [ScoreW-1:0] score;

  modport source (output valid, output operation, output key_bits, output score,
                  input ready);
  modport sink   (input valid, input operation, input key_bits, input score,
                  output ready);
endinterface

interface tdf_out_if
  import tdf_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic [KeyNumW-1:0]       key_number;
  logic [KeyW-1:0]          key_out;
  logic signed [ScoreW-1:0] score_out;

  modport source (output valid, output status, output key_number, output key_out,
                  output score_out, input ready);
  modport sink   (input valid, input status, input key_number, input key_out,
                  input score_out, output ready);
endinterface

[hw/rtl/threshold_dedup_filter.sv]
// Top level of the threshold filter with duplicate removal.
// Each input item is a candidate (tested against the score threshold first) or a
// preload key; a key that is new is stored in a 1024-entry table and numbered from
// one, and every item gives exactly one result item. After capture the table is
// searched linearly through its single read port, one stored key per cycle, then
// the status is formed and the result register loaded; a candidate below the
// threshold skips the search. A new item is taken while the previous result
// still waits in the result register. The table needs no clearing after reset:
// only entries below the fill count are ever read. Write the threshold only
// while idle.
module threshold_dedup_filter
  import tdf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic signed [ScoreW-1:0] cfg_wdata_i,
  tdf_in_if.sink                   in_i,
  tdf_out_if.source                out_o
);

  cmd_t    cmd;
  sts_t    sts;
  logic    in_ready;
  status_e status;

  // Control.
  tdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Data path.
  tdf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .operation_i  (in_i.operation),
    .key_bits_i   (in_i.key_bits),
    .score_i      (in_i.score),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .status_o     (status),
    .key_number_o (out_o.key_number),
    .key_out_o    (out_o.key_out),
    .score_out_o  (out_o.score_out)
  );

  assign in_i.ready   = in_ready;
  assign out_o.status = status;

endmodule

[hw/rtl/tdf_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module tdf_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tdf_ctrl.sv]
// Controller state machine: sequences capture, table search, store and result.
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        search_done;

  // The search is over once every stored key is read and the last one compared.
  assign search_done = sts_i.issue_done && !sts_i.rd_pending;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtrlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CtrlIdle: begin
        if (in_valid_i) begin
          state_d = CtrlSearch;
        end
      end
      CtrlSearch: begin
        if (sts_i.below || search_done) begin
          state_d = CtrlFinish;
        end
      end
      CtrlFinish: begin
        if (sts_i.out_free) begin
          state_d = CtrlIdle;
        end
      end
      default: state_d = CtrlIdle;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.status   = StAccepted;
    unique case (state_q)
      CtrlIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      CtrlSearch: begin
        cmd_o.search = !sts_i.below;
      end
      CtrlFinish: begin
        cmd_o.load = sts_i.out_free;
        if (sts_i.below) begin
          cmd_o.status = StBelow;
        end else if (sts_i.hit) begin
          cmd_o.status = StDuplicate;
        end else if (sts_i.full) begin
          cmd_o.status = StFull;
        end else begin
          cmd_o.store  = sts_i.out_free;
          cmd_o.status = sts_i.preload ? StPreloaded : StAccepted;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/tdf_dp.sv]
// Datapath: threshold register, item registers, key table, search and result register.
module tdf_dp
  import tdf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic signed [ScoreW-1:0] cfg_wdata_i,
  input  logic                     operation_i,
  input  logic [KeyW-1:0]          key_bits_i,
  input  logic signed [ScoreW-1:0] score_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output status_e                  status_o,
  output logic [KeyNumW-1:0]       key_number_o,
  output logic [KeyW-1:0]          key_out_o,
  output logic signed [ScoreW-1:0] score_out_o
);

  logic signed [ScoreW-1:0] thr_q;
  logic                     op_q;
  logic [KeyW-1:0]          key_q;
  logic signed [ScoreW-1:0] score_q;
  logic [CountW-1:0]        count_q, count_d;
  logic [CountW-1:0]        idx_q, idx_d;
  logic                     rd_vld_q;
  logic                     hit_q, hit_d;
  logic                     issue;
  logic [KeyW-1:0]          rdata;
  logic                     out_valid_q, out_valid_d;
  status_e                  status_q;
  logic [KeyNumW-1:0]       number_q;
  logic [KeyW-1:0]          key_out_q;
  logic signed [ScoreW-1:0] score_out_q;

  // Score threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Item registers, loaded when an item is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      key_q   <= key_bits_i & KeyMask;
      score_q <= score_i;
    end
  end

  // Search address: one table read per cycle up to the fill count.
  assign issue = cmd_i.search && (idx_q != count_q);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.capture) begin
      idx_d = '0;
    end else if (issue) begin
      idx_d = idx_q + CountW'(1);
    end
  end

  // Compare each returned key with the item's key.
  always_comb begin
    hit_d = hit_q;
    if (cmd_i.capture) begin
      hit_d = 1'b0;
    end else if (rd_vld_q && (rdata == key_q)) begin
      hit_d = 1'b1;
    end
  end

  // Fill count, advanced when a new key is stored.
  assign count_d = cmd_i.store ? count_q + CountW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      count_q  <= '0;
    end else begin
      idx_q    <= idx_d;
      rd_vld_q <= issue;
      hit_q    <= hit_d;
      count_q  <= count_d;
    end
  end

  // Key table.
  tdf_ram #(
    .Width (KeyW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (key_q),
    .re_i    (issue),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Result register; it holds a finished item until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q    <= cmd_i.status;
      number_q    <= cmd_i.store ? KeyNumW'(count_q + CountW'(1)) : '0;
      key_out_q   <= key_q;
      score_out_q <= score_q;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.preload    = op_q;
    sts_o.below      = !op_q && (score_q < thr_q);
    sts_o.hit        = hit_q;
    sts_o.full       = (count_q == CountW'(TableDepth));
    sts_o.issue_done = (idx_q == count_q);
    sts_o.rd_pending = rd_vld_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign key_number_o = number_q;
  assign key_out_o    = key_out_q;
  assign score_out_o  = score_out_q;

endmodule

[tb/sv/tdf_tb_pkg.sv]
// Scoreboard for the threshold and duplicate filter testbench: result prediction and checking.
package tdf_tb_pkg;
  import tdf_pkg::*;

  // Operation codes of an input item.
  localparam logic OpCandidate = 1'b0;
  localparam logic OpPreload   = 1'b1;

  // Only this many mismatches are printed in full.
  localparam int ReportLimit = 10;

  typedef struct {
    status_e                  status;
    logic [KeyNumW-1:0]       key_number;
    logic [KeyW-1:0]          key_out;
    logic signed [ScoreW-1:0] score_out;
  } filter_result_t;

  class dedup_scoreboard;
    logic signed [ScoreW-1:0] threshold;
    bit                       key_stored[bit [KeyW-1:0]];
    int                       stored_count;
    filter_result_t           expected_results[$];
    int                       mismatches;

    function new();
      threshold    = '0;
      stored_count = 0;
      mismatches   = 0;
    endfunction

    function void set_threshold(input logic signed [ScoreW-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Work out the result of one accepted item and update the copy of the key table.
    function void predict_item(input logic op, input logic [KeyW-1:0] key,
                               input logic signed [ScoreW-1:0] score);
      filter_result_t res;
      bit [KeyW-1:0]  masked;
      masked         = key & KeyMask;
      res.key_number = '0;
      res.key_out    = masked;
      res.score_out  = score;
      // The threshold test comes first, then the search, then the fill level.
      if (op == OpCandidate && score < threshold) begin
        res.status = StBelow;
      end else if (key_stored.exists(masked)) begin
        res.status = StDuplicate;
      end else if (stored_count >= TableDepth) begin
        res.status = StFull;
      end else begin
        key_stored[masked] = 1'b1;
        stored_count++;
        res.key_number = KeyNumW'(stored_count);
        res.status     = (op == OpPreload) ? StPreloaded : StAccepted;
      end
      expected_results.push_back(res);
    endfunction

    // Compare one result item with the oldest outstanding expectation.
    function void check_result(input logic [StatusW-1:0] status,
                               input logic [KeyNumW-1:0] number,
                               input logic [KeyW-1:0] key,
                               input logic signed [ScoreW-1:0] score);
      filter_result_t exp;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("unexpected result: status %0d number %0d key %h score %h",
                   status, number, key, score);
        end
      end else begin
        exp = expected_results.pop_front();
        if (status !== exp.status || number !== exp.key_number ||
            key !== exp.key_out || score !== exp.score_out) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("result mismatch: expected status %0d number %0d key %h score %h",
                     exp.status, exp.key_number, exp.key_out, exp.score_out);
            $display("                 got      status %0d number %0d key %h score %h",
                     status, number, key, score);
          end
        end
      end
    endfunction
  endclass

endpackage

[tb/sv/threshold_dedup_filter_tb.sv]
// Top module of the threshold and duplicate filter testbench.
module threshold_dedup_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdf_pkg::*;
  import tdf_tb_pkg::*;

  localparam int ResetCycles = 7;
  localparam int IdlePct     = 35;
  localparam int HoldCycles  = 1500;
  // The watchdog limit covers a full-table search plus the receiver hold-off.
  localparam int WatchdogLimit = 20000;
  localparam int PhaseItems    = 97;

  localparam logic signed [ScoreW-1:0] MaxScore = 32'sh7fff_ffff;
  localparam logic signed [ScoreW-1:0] MinScore = 32'sh8000_0000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic signed [ScoreW-1:0] cfg_wdata_i;

  tdf_in_if  in_bus ();
  tdf_out_if out_bus ();

  threshold_dedup_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  dedup_scoreboard ledger = new();
  logic [KeyW-1:0] sent_keys[$];
  bit              no_idle;
  bit              pressure_request;
  bit              pressure_done;
  int              hold_left;
  int              stall_cycles;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random ready, with one long hold-off on request.
  always @(negedge clk_i) begin
    if (pressure_request && !pressure_done) begin
      hold_left     = HoldCycles;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // Result checking and the count of cycles without any handshake.
  always @(posedge clk_i) begin
    if (out_bus.valid && out_bus.ready) begin
      ledger.check_result(out_bus.status, out_bus.key_number, out_bus.key_out,
                          out_bus.score_out);
    end
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
  end

  // Watchdog.
  initial begin
    wait (stall_cycles >= WatchdogLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [KeyW-1:0] fresh_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KeyW-1:0] known_key();
    if (sent_keys.size() == 0) begin
      return fresh_key();
    end
    return sent_keys[$urandom_range(sent_keys.size() - 1)];
  endfunction

  // Scores cluster around the threshold, with extremes and fully random values.
  function automatic logic signed [ScoreW-1:0] random_score();
    int                       pick;
    logic signed [ScoreW-1:0] thr;
    thr  = ledger.threshold;
    pick = $urandom_range(99);
    if (pick < 35) begin
      return $urandom();
    end else if (pick < 60) begin
      return thr + 32'($urandom_range(8)) - 32'd4;
    end else if (pick < 70) begin
      return $urandom_range(1) ? MaxScore : MinScore;
    end
    return thr + 32'($urandom_range(32'h0004_0000));
  endfunction

  // Offer one item after a random gap and wait until it is accepted.
  task automatic offer_item(input logic op, input logic [KeyW-1:0] key,
                            input logic signed [ScoreW-1:0] score);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      @(negedge clk_i);
      in_bus.valid     <= 1'b0;
      in_bus.operation <= 1'($urandom_range(1));
      in_bus.key_bits  <= fresh_key();
      in_bus.score     <= $urandom();
    end
    @(negedge clk_i);
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.key_bits  <= key;
    in_bus.score     <= score;
    do @(posedge clk_i); while (!in_bus.ready);
    ledger.predict_item(op, key, score);
    sent_keys.push_back(key);
  endtask

  // Mix of new keys, repeats, one-bit neighbours of known keys and preloads.
  task automatic offer_random_item();
    int              pick;
    logic            op;
    logic [KeyW-1:0] key;
    pick = $urandom_range(99);
    if (pick < 15) begin
      op  = OpPreload;
      key = fresh_key();
    end else if (pick < 25) begin
      op  = OpPreload;
      key = known_key();
    end else if (pick < 55) begin
      op  = OpCandidate;
      key = fresh_key();
    end else if (pick < 75) begin
      op  = OpCandidate;
      key = known_key();
    end else if (pick < 85) begin
      op  = OpCandidate;
      key = known_key() ^ (64'd1 << $urandom_range(KeyW - 1));
    end else begin
      op  = 1'($urandom_range(1));
      key = fresh_key();
    end
    offer_item(op, key, random_score());
  endtask

  // Let the block go idle, then write the threshold.
  task automatic write_threshold(input logic signed [ScoreW-1:0] value);
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ledger.set_threshold(value);
  endtask

  // Field extremes and the special cases, first under the reset threshold of zero.
  task automatic run_directed();
    offer_item(OpCandidate, 64'd0, 32'sd0);
    offer_item(OpCandidate, 64'd1, -32'sd1);
    offer_item(OpCandidate, 64'd0, MaxScore);
    offer_item(OpPreload, '1, 32'sd0);
    offer_item(OpPreload, '1, MinScore);
    offer_item(OpPreload, 64'h5555_5555_5555_5555, MinScore);
    // Below threshold wins over duplicate.
    offer_item(OpCandidate, '1, MinScore);
    offer_item(OpCandidate, 64'h8000_0000_0000_0000, MaxScore);
    offer_item(OpCandidate, 64'h7fff_ffff_ffff_ffff, 32'sd1);
    offer_item(OpCandidate, 64'd1, 32'sh0001_0000);
    offer_item(OpCandidate, 64'd1, 32'sd0);
    offer_item(OpCandidate, 64'haaaa_aaaa_aaaa_aaaa, MinScore);
    offer_item(OpPreload, 64'haaaa_aaaa_aaaa_aaaa, MaxScore);
    write_threshold(MaxScore);
    offer_item(OpCandidate, fresh_key(), MaxScore);
    offer_item(OpCandidate, fresh_key(), MaxScore - 32'sd1);
    offer_item(OpPreload, fresh_key(), MinScore);
    write_threshold(MinScore);
    offer_item(OpCandidate, fresh_key(), MinScore);
    offer_item(OpCandidate, 64'd0, MinScore);
    offer_item(OpCandidate, fresh_key(), $urandom());
  endtask

  // Items against a full table: nothing new is stored any more.
  task automatic run_full_table();
    write_threshold(-32'sh0001_0000);
    offer_item(OpPreload, fresh_key(), $urandom());
    offer_item(OpCandidate, fresh_key(), MaxScore);
    // Duplicate wins over table full.
    offer_item(OpCandidate, 64'd0, MaxScore);
    offer_item(OpPreload, '1, MinScore);
    offer_item(OpCandidate, 64'd0, MinScore);
    write_threshold(MaxScore);
    offer_item(OpCandidate, fresh_key(), MaxScore);
    offer_item(OpCandidate, 64'd1, MaxScore - 32'sd1);
    write_threshold(MinScore);
    offer_item(OpCandidate, fresh_key(), MinScore);
    offer_item(OpPreload, fresh_key(), MaxScore);
    repeat (4) offer_random_item();
  endtask

  // Main sequence.
  initial begin
    in_bus.valid     = 1'b0;
    in_bus.operation = 1'b0;
    in_bus.key_bits  = '0;
    in_bus.score     = '0;
    out_bus.ready    = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    rst_ni           = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // Random phases over a range of thresholds.
    write_threshold($urandom());
    repeat (PhaseItems) offer_random_item();
    write_threshold(32'sh0001_0000);
    repeat (20) offer_random_item();
    pressure_request = 1'b1;
    repeat (PhaseItems - 20) offer_random_item();
    write_threshold(MinScore);
    repeat (PhaseItems) offer_random_item();
    write_threshold($urandom());
    no_idle = 1'b1;
    repeat (PhaseItems) offer_random_item();
    no_idle = 1'b0;
    write_threshold(MaxScore);
    repeat (PhaseItems) offer_random_item();
    write_threshold(-32'sh0000_8000);
    repeat (PhaseItems) offer_random_item();

    // Fill the table, mostly with new preloads to keep the run short.
    write_threshold($urandom());
    while (ledger.stored_count < TableDepth) begin
      if ($urandom_range(99) < 93) begin
        offer_item(OpPreload, fresh_key(), $urandom());
      end else begin
        offer_random_item();
      end
    end
    run_full_table();

    // Drain, then watch for stray results for about one full search.
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (TableDepth + 16) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
